### sv/bgd_pkg.sv
`default_nettype none

package bgd_pkg;

  // Register file geometry
  localparam int unsigned RegW     = 16;
  localparam int unsigned NumRegs  = 7;
  localparam int unsigned RegIdxW  = 3;

  // Counter width default
  localparam int unsigned CountBitsDefault = 16;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CLICK_GAP  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DOUBLE_GAP = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SETTLE     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_HOLD       = 3'd5;
  localparam logic [RegIdxW-1:0] REG_RESET      = 3'd6;

  // Register reset values
  localparam logic [RegW-1:0] DebounceRst  = 16'd10;
  localparam logic [RegW-1:0] LongPressRst = 16'd3000;
  localparam logic [RegW-1:0] ClickGapRst  = 16'd200;
  localparam logic [RegW-1:0] DoubleGapRst = 16'd100;
  localparam logic [RegW-1:0] SettleRst    = 16'd100;
  localparam logic [RegW-1:0] HoldRst      = 16'd6000;
  localparam logic [RegW-1:0] ResetRst     = 16'd10000;

  // Gesture codes
  localparam int unsigned GestureW = 3;
  localparam logic [GestureW-1:0] G_NONE   = 3'd0;
  localparam logic [GestureW-1:0] G_CLICK  = 3'd1;
  localparam logic [GestureW-1:0] G_DOUBLE = 3'd2;
  localparam logic [GestureW-1:0] G_LONG   = 3'd3;
  localparam logic [GestureW-1:0] G_HOLD   = 3'd4;

  // Phase codes
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PH_WAIT_UP   = 4'd0;
  localparam logic [PhaseW-1:0] PH_WAIT_DOWN = 4'd1;
  localparam logic [PhaseW-1:0] PH_DEBOUNCE  = 4'd2;
  localparam logic [PhaseW-1:0] PH_PRESSED   = 4'd3;
  localparam logic [PhaseW-1:0] PH_GAP       = 4'd4;
  localparam logic [PhaseW-1:0] PH_SECOND    = 4'd5;
  localparam logic [PhaseW-1:0] PH_DOUBLE_UP = 4'd6;
  localparam logic [PhaseW-1:0] PH_EXIT      = 4'd10;

  // Stream byte widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic [RegW-1:0] debounce_ticks;
    logic [RegW-1:0] long_press_ticks;
    logic [RegW-1:0] click_gap_ticks;
    logic [RegW-1:0] double_gap_ticks;
    logic [RegW-1:0] settle_ticks;
    logic [RegW-1:0] hold_ticks;
    logic [RegW-1:0] reset_ticks;
  } cfg_t;

  typedef struct packed {
    logic [GestureW-1:0] gesture;
    logic                reset_request;
  } result_t;

endpackage

`default_nettype wire

### sv/bgd_step.sv
`default_nettype none

module bgd_step #(
  parameter int unsigned COUNT_BITS = bgd_pkg::CountBitsDefault
) (
  input  bgd_pkg::cfg_t                  cfg_i,
  input  logic [bgd_pkg::PhaseW-1:0]     phase_i,
  input  logic [COUNT_BITS-1:0]          press_cnt_i,
  input  logic [COUNT_BITS-1:0]          release_cnt_i,
  input  logic                           key_level_i,
  input  logic                           display_active_i,
  output logic [bgd_pkg::PhaseW-1:0]     phase_o,
  output logic [COUNT_BITS-1:0]          press_cnt_o,
  output logic [COUNT_BITS-1:0]          release_cnt_o,
  output bgd_pkg::result_t               result_o
);

  // Compare width covers both counter and register
  localparam int unsigned CW = (COUNT_BITS > bgd_pkg::RegW) ? COUNT_BITS : bgd_pkg::RegW;

  logic                  press_step;
  logic                  release_step;
  logic [COUNT_BITS-1:0] press_inc;
  logic [COUNT_BITS-1:0] release_inc;
  logic [CW-1:0]         press_inc_x;
  logic [CW-1:0]         release_x;
  logic [CW-1:0]         release_inc_x;

  // Saturating increments
  assign press_step    = (press_cnt_i != '1);
  assign release_step  = (release_cnt_i != '1);
  assign press_inc     = press_step ? press_cnt_i + 1'b1 : press_cnt_i;
  assign release_inc   = release_step ? release_cnt_i + 1'b1 : release_cnt_i;
  assign press_inc_x   = CW'(press_inc);
  assign release_x     = CW'(release_cnt_i);
  assign release_inc_x = CW'(release_inc);

  // Phase machine for one tick
  always_comb begin
    phase_o                = phase_i;
    press_cnt_o            = press_cnt_i;
    release_cnt_o          = release_cnt_i;
    result_o.gesture       = bgd_pkg::G_NONE;
    result_o.reset_request = 1'b0;

    unique case (phase_i)
      bgd_pkg::PH_WAIT_DOWN: begin
        if (key_level_i) begin
          phase_o     = bgd_pkg::PH_DEBOUNCE;
          press_cnt_o = '0;
        end
      end
      bgd_pkg::PH_DEBOUNCE: begin
        press_cnt_o = press_inc;
        if (key_level_i) begin
          if (press_inc_x > CW'(cfg_i.debounce_ticks)) begin
            phase_o = bgd_pkg::PH_PRESSED;
          end
        end else begin
          phase_o = bgd_pkg::PH_WAIT_UP;
        end
      end
      bgd_pkg::PH_PRESSED: begin
        if (key_level_i) begin
          press_cnt_o = press_inc;
          if (press_inc_x > CW'(cfg_i.long_press_ticks)) begin
            result_o.gesture = bgd_pkg::G_LONG;
            release_cnt_o    = '0;
            phase_o          = bgd_pkg::PH_EXIT;
          end
        end else begin
          release_cnt_o = '0;
          phase_o       = bgd_pkg::PH_GAP;
        end
      end
      bgd_pkg::PH_GAP: begin
        if (!key_level_i) begin
          // compare the count as it stood before this tick
          release_cnt_o = release_inc;
          if (release_x > CW'(cfg_i.click_gap_ticks)) begin
            result_o.gesture = bgd_pkg::G_CLICK;
            phase_o          = bgd_pkg::PH_WAIT_UP;
          end
        end else begin
          phase_o       = bgd_pkg::PH_SECOND;
          press_cnt_o   = '0;
          release_cnt_o = '0;
        end
      end
      bgd_pkg::PH_SECOND: begin
        if (key_level_i) begin
          press_cnt_o   = press_inc;
          release_cnt_o = '0;
          if (press_inc_x > CW'(cfg_i.debounce_ticks)) begin
            phase_o = bgd_pkg::PH_DOUBLE_UP;
          end
        end else begin
          press_cnt_o   = '0;
          release_cnt_o = release_inc;
          if (release_inc_x > CW'(cfg_i.double_gap_ticks)) begin
            phase_o = bgd_pkg::PH_WAIT_UP;
          end
        end
      end
      bgd_pkg::PH_DOUBLE_UP: begin
        // a press here changes nothing
        if (!key_level_i) begin
          release_cnt_o = release_inc;
          if (release_inc_x > CW'(cfg_i.settle_ticks)) begin
            result_o.gesture = bgd_pkg::G_DOUBLE;
            phase_o          = bgd_pkg::PH_WAIT_UP;
          end
        end
      end
      bgd_pkg::PH_EXIT: begin
        if (!key_level_i) begin
          release_cnt_o = release_inc;
          if (release_inc_x > CW'(cfg_i.settle_ticks)) begin
            phase_o = bgd_pkg::PH_WAIT_UP;
          end
        end else begin
          press_cnt_o = press_inc;
          // hold fires only when the counter steps onto the mark
          if (press_inc_x == CW'(cfg_i.hold_ticks)) begin
            if (press_step) begin
              result_o.gesture = bgd_pkg::G_HOLD;
            end
          end else if (press_inc_x > CW'(cfg_i.reset_ticks)) begin
            result_o.reset_request = 1'b1;
          end
        end
      end
      default: begin
        // wait for release; unused codes land here too
        if (!key_level_i) begin
          phase_o = bgd_pkg::PH_WAIT_DOWN;
        end
      end
    endcase

    // Inactive display: back to waiting for release, drop the gesture, keep counters
    if (!display_active_i) begin
      phase_o          = bgd_pkg::PH_WAIT_UP;
      result_o.gesture = bgd_pkg::G_NONE;
    end
  end

endmodule

`default_nettype wire

### sv/button_gesture_detector.sv
// Each accepted sample's result beat is registered in the output slot and is presented the cycle after.
// Throughput: one sample per cycle; the phase and counter update is one combinational pass.
// The output register frees in the cycle its beat is taken, so a draining slot never stalls
// input; a full slot that is not taken holds input until the result side is ready.
// Reset (rst_ni low, asynchronous): phase waits for release, counters are zero, output
// is empty, and the seven timing registers return to their default tick counts.
`default_nettype none

module button_gesture_detector #(
  parameter int unsigned COUNT_BITS = bgd_pkg::CountBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [bgd_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [bgd_pkg::RegW-1:0]      cfg_data_i,
  // Sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bgd_pkg::InDataW-1:0]   s_axis_tdata,  // [0] key_level, [1] display_active
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bgd_pkg::OutDataW-1:0]  m_axis_tdata   // [2:0] gesture, [3] reset_request
);

  bgd_pkg::cfg_t                cfg_q;
  logic [bgd_pkg::PhaseW-1:0]   phase_q;
  logic [bgd_pkg::PhaseW-1:0]   phase_d;
  logic [COUNT_BITS-1:0]        press_cnt_q;
  logic [COUNT_BITS-1:0]        press_cnt_d;
  logic [COUNT_BITS-1:0]        release_cnt_q;
  logic [COUNT_BITS-1:0]        release_cnt_d;
  bgd_pkg::result_t             result_d;
  bgd_pkg::result_t             result_q;
  logic                         out_valid_q;
  logic                         in_fire;

  // Accept while the output slot is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= bgd_pkg::DebounceRst;
      cfg_q.long_press_ticks <= bgd_pkg::LongPressRst;
      cfg_q.click_gap_ticks  <= bgd_pkg::ClickGapRst;
      cfg_q.double_gap_ticks <= bgd_pkg::DoubleGapRst;
      cfg_q.settle_ticks     <= bgd_pkg::SettleRst;
      cfg_q.hold_ticks       <= bgd_pkg::HoldRst;
      cfg_q.reset_ticks      <= bgd_pkg::ResetRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bgd_pkg::REG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data_i;
        bgd_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        bgd_pkg::REG_CLICK_GAP:  cfg_q.click_gap_ticks  <= cfg_data_i;
        bgd_pkg::REG_DOUBLE_GAP: cfg_q.double_gap_ticks <= cfg_data_i;
        bgd_pkg::REG_SETTLE:     cfg_q.settle_ticks     <= cfg_data_i;
        bgd_pkg::REG_HOLD:       cfg_q.hold_ticks       <= cfg_data_i;
        bgd_pkg::REG_RESET:      cfg_q.reset_ticks      <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  bgd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cfg_i            (cfg_q),
    .phase_i          (phase_q),
    .press_cnt_i      (press_cnt_q),
    .release_cnt_i    (release_cnt_q),
    .key_level_i      (s_axis_tdata[0]),
    .display_active_i (s_axis_tdata[1]),
    .phase_o          (phase_d),
    .press_cnt_o      (press_cnt_d),
    .release_cnt_o    (release_cnt_d),
    .result_o         (result_d)
  );

  // Advance the machine on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= bgd_pkg::PH_WAIT_UP;
      press_cnt_q   <= '0;
      release_cnt_q <= '0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      press_cnt_q   <= press_cnt_d;
      release_cnt_q <= release_cnt_d;
    end
  end

  // Output slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output slot payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bgd_pkg::OutDataW - bgd_pkg::GestureW - 1){1'b0}},
                          result_q.reset_request, result_q.gesture};

  // A reset request only comes out of the long-press exit phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (!m_axis_tdata[3] || $past(phase_q) == bgd_pkg::PH_EXIT))
    else $error("reset request outside exit phase");

  // An inactive display suppresses the gesture and parks the machine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !s_axis_tdata[1]) |=>
      (m_axis_tdata[2:0] == bgd_pkg::G_NONE && phase_q == bgd_pkg::PH_WAIT_UP))
    else $error("gesture or phase not cleared with display inactive");

  // A hold beat means the press counter sits on the hold mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (m_axis_tdata[2:0] != bgd_pkg::G_HOLD ||
                 press_cnt_q == COUNT_BITS'(cfg_q.hold_ticks)))
    else $error("hold gesture off the hold mark");

  // A click is only reported on a released sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (m_axis_tdata[2:0] != bgd_pkg::G_CLICK || !$past(s_axis_tdata[0])))
    else $error("click reported on a pressed sample");

endmodule

`default_nettype wire
